// ----- design/mpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfa_pkg
// Shared types and constants for the multi-pool free-list allocator.
// ----------------------------------------------------------------------------
package mpfa_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int POOL_W   = 3;
    localparam int ADDR_W   = 10;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;
    localparam int FED_W    = 11;
    localparam int LINK_W   = ADDR_W + 1;
    localparam int WALK_W   = 12;

    // Granule address space seen by the request fields
    localparam int ADDR_SPACE = 1 << ADDR_W;

    // Configuration registers
    localparam int REG_COUNT  = 8;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_POOLS  = 8;
    localparam int DEF_LINK_DEPTH = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FEED  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_UNUSED = 2'd2,
        STAT_TRUNC  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ALLOC_DATA,
        S_FEED_WALK,
        S_HOLD
    } t_state;

    // Head register and link entry: valid bit over a granule address
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_link;

    typedef struct packed {
        logic [FED_W-1:0]  fed;
        logic              more;
        t_status           status;
        logic [ADDR_W-1:0] granted;
    } t_result;

endpackage

// ----- design/mpfa_ram.sv -----
// ----------------------------------------------------------------------------
// mpfa_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mpfa_regs.sv -----
// ----------------------------------------------------------------------------
// mpfa_regs
// APB register file holding the element size of each pool.
// ----------------------------------------------------------------------------
module mpfa_regs (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  psel,
    input  logic                                                  penable,
    input  logic                                                  pwrite,
    input  logic [mpfa_pkg::APB_ADDR_W-1:0]                       paddr,
    input  logic [mpfa_pkg::APB_DATA_W-1:0]                       pwdata,
    output logic [mpfa_pkg::APB_DATA_W-1:0]                       prdata,
    output logic                                                  pready,
    output logic [mpfa_pkg::REG_COUNT-1:0][mpfa_pkg::SIZE_W-1:0]  o_sizes
);

    logic [mpfa_pkg::REG_COUNT-1:0][mpfa_pkg::SIZE_W-1:0] r_size;
    logic [mpfa_pkg::REG_IDX_W-1:0]                       reg_idx;
    logic                                                 wr_en;

    assign reg_idx = paddr[mpfa_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mpfa_pkg::REG_COUNT; i++) begin
                r_size[i] <= '0;
            end
        end else if (wr_en) begin
            r_size[reg_idx] <= pwdata[mpfa_pkg::SIZE_W-1:0];
        end
    end

    assign prdata  = mpfa_pkg::APB_DATA_W'(r_size[reg_idx]);
    assign pready  = 1'b1;
    assign o_sizes = r_size;

endmodule

// ----- design/multi_pool_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// multi_pool_free_list_allocator
// Fixed-size block allocator: per-pool LIFO free lists over a link memory.
// ----------------------------------------------------------------------------
// Each pool keeps a head register; the next link of every free block sits in
// a single-port link RAM addressed by the block's granule address, so all link
// reads and writes go through that one port. A request is taken, decoded in the
// following cycle and answered with exactly one result. A free, an operation
// three, an allocate from an empty or absent pool and a feed into an unused
// or absent pool finish in S_EXEC. An allocate that pops a block goes on to
// S_ALLOC_DATA, where the registered link read of the head becomes the new
// head. A feed that walks its region pushes in S_FEED_WALK, one push per cycle.
// The link RAM needs no clearing after reset; a result that cannot leave yet
// is held, and the next request waits for it.
// ----------------------------------------------------------------------------
module multi_pool_free_list_allocator #(
    parameter int NUM_POOLS  = mpfa_pkg::DEF_NUM_POOLS,
    parameter int LINK_DEPTH = mpfa_pkg::DEF_LINK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mpfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] pool, [12:3] block, [23:13] length
    input  logic [mpfa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [mpfa_pkg::OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [9:0] granted, [20:10] fed_count, [23:21] zero
    output logic [mpfa_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] status, [2] more_wanted
    output logic [mpfa_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    localparam int LINK_LIMIT = (LINK_DEPTH < mpfa_pkg::ADDR_SPACE) ?
                                LINK_DEPTH : mpfa_pkg::ADDR_SPACE;
    localparam int LINK_AW    = $clog2(LINK_LIMIT);
    localparam int PIDX_W     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;

    // Configuration registers
    logic [mpfa_pkg::REG_COUNT-1:0][mpfa_pkg::SIZE_W-1:0] sizes;

    mpfa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sizes (sizes)
    );

    // Control state
    mpfa_pkg::t_state r_state, n_state;
    mpfa_pkg::t_link  r_head [NUM_POOLS];
    logic             r_out_valid;

    // Request payload
    mpfa_pkg::t_op                 r_op;
    logic [mpfa_pkg::POOL_W-1:0]   r_pool;
    logic [mpfa_pkg::ADDR_W-1:0]   r_block;
    logic [mpfa_pkg::SIZE_W-1:0]   r_length;

    // Feed walk: r_off is (k+1)*size, r_end is block + r_off
    logic [mpfa_pkg::WALK_W-1:0]   r_off;
    logic [mpfa_pkg::WALK_W-1:0]   r_end;
    logic [mpfa_pkg::FED_W-1:0]    r_fed;

    mpfa_pkg::t_result r_res;
    mpfa_pkg::t_result r_out;

    // Datapath controls
    logic                          in_accept;
    logic                          slot_free;
    logic                          present;
    logic [PIDX_W-1:0]             pidx;
    mpfa_pkg::t_link               head_cur;
    logic [mpfa_pkg::SIZE_W-1:0]   size_cur;
    logic [mpfa_pkg::WALK_W-1:0]   push_a;

    logic                          res_done;
    mpfa_pkg::t_result             res;
    logic                          head_we;
    mpfa_pkg::t_link               head_wdata;
    logic                          mem_we;
    logic [mpfa_pkg::ADDR_W-1:0]   mem_addr;
    mpfa_pkg::t_link               mem_wdata;
    mpfa_pkg::t_link               mem_rdata;
    logic                          feed_init;
    logic                          feed_step;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_out_valid || m_axis_tready;
    assign present   = ({1'b0, r_pool} < (mpfa_pkg::POOL_W + 1)'(NUM_POOLS));
    assign pidx      = r_pool[PIDX_W-1:0];
    assign head_cur  = present ? r_head[pidx] : '0;
    assign size_cur  = sizes[r_pool];
    assign push_a    = r_end - mpfa_pkg::WALK_W'(size_cur);

    mpfa_ram #(
        .WIDTH (mpfa_pkg::LINK_W),
        .DEPTH (LINK_LIMIT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr[LINK_AW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mpfa_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = mpfa_pkg::S_EXEC;
                end
            end
            mpfa_pkg::S_EXEC: begin
                if (res_done) begin
                    n_state = slot_free ? mpfa_pkg::S_IDLE : mpfa_pkg::S_HOLD;
                end else if (r_op == mpfa_pkg::OP_ALLOC) begin
                    n_state = mpfa_pkg::S_ALLOC_DATA;
                end else begin
                    n_state = mpfa_pkg::S_FEED_WALK;
                end
            end
            mpfa_pkg::S_ALLOC_DATA,
            mpfa_pkg::S_FEED_WALK: begin
                if (res_done) begin
                    n_state = slot_free ? mpfa_pkg::S_IDLE : mpfa_pkg::S_HOLD;
                end
            end
            mpfa_pkg::S_HOLD: begin
                if (slot_free) begin
                    n_state = mpfa_pkg::S_IDLE;
                end
            end
            default: n_state = mpfa_pkg::S_IDLE;
        endcase
    end

    // Datapath and result
    always_comb begin
        res_done   = 1'b0;
        res        = '0;
        head_we    = 1'b0;
        head_wdata = head_cur;
        mem_we     = 1'b0;
        mem_addr   = head_cur.addr;
        mem_wdata  = head_cur;
        feed_init  = 1'b0;
        feed_step  = 1'b0;
        case (r_state)
            mpfa_pkg::S_EXEC: begin
                case (r_op)
                    mpfa_pkg::OP_ALLOC: begin
                        // a valid head issues the link read at its address
                        if (!present) begin
                            res_done   = 1'b1;
                            res.status = mpfa_pkg::STAT_EMPTY;
                        end else if (!head_cur.valid) begin
                            res_done   = 1'b1;
                            res.status = mpfa_pkg::STAT_EMPTY;
                            res.more   = 1'b1;
                        end
                    end
                    mpfa_pkg::OP_FREE: begin
                        res_done = 1'b1;
                        if (!present) begin
                            res.status = mpfa_pkg::STAT_UNUSED;
                        end else if ({1'b0, r_block} >=
                                     (mpfa_pkg::ADDR_W + 1)'(LINK_LIMIT)) begin
                            res.status = mpfa_pkg::STAT_TRUNC;
                        end else begin
                            mem_we     = 1'b1;
                            mem_addr   = r_block;
                            head_we    = 1'b1;
                            head_wdata = '{valid: 1'b1, addr: r_block};
                        end
                    end
                    mpfa_pkg::OP_FEED: begin
                        if (!present || size_cur == '0) begin
                            res_done   = 1'b1;
                            res.status = mpfa_pkg::STAT_UNUSED;
                        end else begin
                            feed_init = 1'b1;
                        end
                    end
                    default: begin
                        res_done = 1'b1;
                    end
                endcase
            end
            mpfa_pkg::S_ALLOC_DATA: begin
                res_done    = 1'b1;
                res.granted = head_cur.addr;
                head_we     = 1'b1;
                head_wdata  = mem_rdata;
            end
            mpfa_pkg::S_FEED_WALK: begin
                res.fed = r_fed;
                if (r_off > mpfa_pkg::WALK_W'(r_length)) begin
                    res_done = 1'b1;
                end else if (r_end > mpfa_pkg::WALK_W'(LINK_LIMIT)) begin
                    // element runs past the link memory: stop short
                    res_done   = 1'b1;
                    res.status = mpfa_pkg::STAT_TRUNC;
                end else begin
                    mem_we     = 1'b1;
                    mem_addr   = push_a[mpfa_pkg::ADDR_W-1:0];
                    head_we    = 1'b1;
                    head_wdata = '{valid: 1'b1, addr: push_a[mpfa_pkg::ADDR_W-1:0]};
                    feed_step  = 1'b1;
                end
            end
            default: begin
                res_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpfa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_POOLS; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (head_we) begin
                r_head[pidx] <= head_wdata;
            end
            if ((res_done || r_state == mpfa_pkg::S_HOLD) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= mpfa_pkg::t_op'(s_axis_tuser);
            r_pool   <= s_axis_tdata[2:0];
            r_block  <= s_axis_tdata[12:3];
            r_length <= s_axis_tdata[23:13];
        end
        if (feed_init) begin
            r_off <= mpfa_pkg::WALK_W'(size_cur);
            r_end <= mpfa_pkg::WALK_W'(r_block) + mpfa_pkg::WALK_W'(size_cur);
            r_fed <= '0;
        end else if (feed_step) begin
            r_off <= r_off + mpfa_pkg::WALK_W'(size_cur);
            r_end <= r_end + mpfa_pkg::WALK_W'(size_cur);
            r_fed <= r_fed + 1'b1;
        end
        if (res_done) begin
            r_res <= res;
        end
        if (res_done && slot_free) begin
            r_out <= res;
        end else if (r_state == mpfa_pkg::S_HOLD && slot_free) begin
            r_out <= r_res;
        end
    end

    assign s_axis_tready = (r_state == mpfa_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.fed, r_out.granted};
    assign m_axis_tuser  = {r_out.more, r_out.status};

endmodule
